### sv/fog_parameter_crossfade_unit_assert.svh
// Assertion macros for the fog parameter crossfade unit checker.
// Depends on nothing; the using module provides clk and rst_n.
`ifndef FOG_PARAMETER_CROSSFADE_UNIT_ASSERT_SVH
`define FOG_PARAMETER_CROSSFADE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpc assertion failed");

// Next-cycle implication, disabled in reset.
`define FPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpc assertion failed");

`endif

### sv/fpc_pkg.sv
// Shared widths, reset constants and the 8-bit color reduction.
// No dependencies.
`timescale 1ns / 1ps

package fpc_pkg;

  localparam int DENS_W    = 24;
  localparam int COL_W     = 16;
  localparam int COL8_W    = 8;
  localparam int TICK_W    = 16;
  localparam int NOW_W     = 32;

  localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};
  // 0.3 of full scale in Q0.16
  localparam logic [COL_W-1:0]  COL_TGT_RST = 16'd19661;

  typedef enum logic [1:0] {
    CH_DENS  = 2'd0,
    CH_RED   = 2'd1,
    CH_GREEN = 2'd2,
    CH_BLUE  = 2'd3
  } fpc_ch_t;

  // Q0.16 color to 0..255, round half up: (c*255 + 2^15) >> 16
  function automatic logic [COL8_W-1:0] to8(input logic [COL_W-1:0] c);
    logic [24:0] s;
    s = {1'b0, c, 8'h00} - {9'h000, c} + 25'd32768;
    return s[23:16];
  endfunction

endpackage

### sv/fog_parameter_crossfade_unit.sv
// Fog parameter crossfade: linear fade of density and RGB toward a target.
// One item at a time, taken in idle once the last result has left HOLD. Sampling and
// immediate loads run one pass; a fade load blends the start values, then runs a second
// pass; a pass with no fade running skips the one-bit-per-cycle divider. A single
// multiplier is shared over four channels. A finished result waits in the output register
// while the next item is taken. Sync active-low reset restores the fog defaults.
`timescale 1ns / 1ps

module fog_parameter_crossfade_unit
  import fpc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [NOW_W-1:0]    in_now,
  input  logic [DENS_W-1:0]   in_new_density,
  input  logic [COL_W-1:0]    in_new_red,
  input  logic [COL_W-1:0]    in_new_green,
  input  logic [COL_W-1:0]    in_new_blue,
  input  logic [TICK_W-1:0]   in_fade_ticks,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DENS_W-1:0]   out_density_out,
  output logic [COL8_W-1:0]   out_red_out,
  output logic [COL8_W-1:0]   out_green_out,
  output logic [COL8_W-1:0]   out_blue_out
);

  // Blend factor f: FRAC_BITS fraction bits, range 0..1 inclusive.
  localparam int QW = FRAC_BITS + 1;
  localparam int PW = QW + DENS_W;          // product width
  localparam int AW = PW + 1;               // f*s + (1-f)*t + half
  localparam int VW = AW - FRAC_BITS;       // mixed value before saturation
  localparam int TW = TIME_BITS;
  localparam int EW = TIME_BITS + 1;        // fade end carries one extra bit
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int RW = TICK_W + 1;           // divider partial remainder

  localparam logic [QW-1:0] ONE_F  = QW'(1) << FRAC_BITS;
  localparam logic [AW-1:0] HALF_F = AW'(1) << (FRAC_BITS - 1);

  // Sequencer: SETUP works out whether a fade runs, DIV makes f one bit per cycle,
  // then MUL_S / MUL_T / MIX run once per channel through the shared multiplier.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_MUL_S = 7'b0001000,
    ST_MUL_T = 7'b0010000,
    ST_MIX   = 7'b0100000,
    ST_HOLD  = 7'b1000000
  } fpc_state_t;

  fpc_state_t state_r, state_nxt;

  // fade state
  logic [DENS_W-1:0] tgt_dens_r, start_dens_r;
  logic [COL_W-1:0]  tgt_red_r, tgt_green_r, tgt_blue_r;
  logic [COL_W-1:0]  start_red_r, start_green_r, start_blue_r;
  logic [TICK_W-1:0] fade_len_r;
  logic [EW-1:0]     fade_end_r;

  // item being worked on
  logic              upd_r;        // fading load: start values first take the blend
  logic [TW-1:0]     t_r;
  logic [DENS_W-1:0] nd_r;
  logic [COL_W-1:0]  nr_r, ng_r, nb_r;
  logic [TICK_W-1:0] ticks_r;

  // datapath
  logic [RW-1:0]     div_rem_r;
  logic [CW-1:0]     div_cnt_r;
  logic [QW-1:0]     f_r;
  fpc_ch_t           ch_r;
  logic [PW-1:0]     prod_r;
  logic [AW-1:0]     acc_r;

  // finished result, then the output register
  logic [DENS_W-1:0] res_dens_r;
  logic [COL8_W-1:0] res_red_r, res_green_r, res_blue_r;
  logic              out_valid_r;
  logic [DENS_W-1:0] out_dens_r;
  logic [COL8_W-1:0] out_red_r, out_green_r, out_blue_r;

  logic              in_acc;
  logic              out_load;
  logic              fade_active;
  logic [EW-1:0]     rem_full;
  logic [TICK_W-1:0] rem_clip;
  logic [RW-1:0]     div_trial;
  logic              div_ge;
  logic              div_last;
  logic [QW-1:0]     mul_a;
  logic [DENS_W-1:0] mul_b;
  logic [PW-1:0]     mul_p;
  logic [DENS_W-1:0] sel_start, sel_tgt;
  logic [AW-1:0]     mix_sum;
  logic [VW-1:0]     mix_v;
  logic [DENS_W-1:0] mix_dens;
  logic [COL_W-1:0]  mix_col;
  logic              last_ch;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  // A fade runs only while fade_end lies ahead and the length is nonzero.
  // Remaining time is clamped to the length so a backward clock shows the start values.
  assign fade_active = (fade_len_r != '0) && (fade_end_r > EW'(t_r));
  assign rem_full    = fade_end_r - EW'(t_r);
  assign rem_clip    = (rem_full > EW'(fade_len_r)) ? fade_len_r : rem_full[TICK_W-1:0];

  // Restoring divide of rem << FRAC_BITS by the fade length; the first step weighs 1.0.
  assign div_trial = (div_cnt_r == '0) ? div_rem_r : {div_rem_r[RW-2:0], 1'b0};
  assign div_ge    = (div_trial >= RW'(fade_len_r));
  assign div_last  = (div_cnt_r == CW'(FRAC_BITS));

  always_comb begin
    case (ch_r)
      CH_DENS: begin
        sel_start = start_dens_r;
        sel_tgt   = tgt_dens_r;
      end
      CH_RED: begin
        sel_start = DENS_W'(start_red_r);
        sel_tgt   = DENS_W'(tgt_red_r);
      end
      CH_GREEN: begin
        sel_start = DENS_W'(start_green_r);
        sel_tgt   = DENS_W'(tgt_green_r);
      end
      default: begin
        sel_start = DENS_W'(start_blue_r);
        sel_tgt   = DENS_W'(tgt_blue_r);
      end
    endcase
  end

  // the one shared multiplier: f*start, then (1-f)*target
  assign mul_a = (state_r == ST_MUL_S) ? f_r : (ONE_F - f_r);
  assign mul_b = (state_r == ST_MUL_S) ? sel_start : sel_tgt;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign mix_sum  = acc_r + AW'(prod_r);
  assign mix_v    = VW'(mix_sum >> FRAC_BITS);
  assign mix_dens = (mix_v > VW'(DENS_MAX)) ? DENS_MAX : mix_v[DENS_W-1:0];
  assign mix_col  = (mix_v > VW'(COL_MAX)) ? COL_MAX : mix_v[COL_W-1:0];
  assign last_ch  = (ch_r == CH_BLUE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = fade_active ? ST_DIV : ST_MUL_S;
      ST_DIV:   if (div_last) state_nxt = ST_MUL_S;
      ST_MUL_S: state_nxt = ST_MUL_T;
      ST_MUL_T: state_nxt = ST_MIX;
      ST_MIX: begin
        if (!last_ch) begin
          state_nxt = ST_MUL_S;
        end else if (upd_r) begin
          state_nxt = ST_SETUP;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control and fade state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      upd_r         <= 1'b0;
      tgt_dens_r    <= '0;
      tgt_red_r     <= COL_TGT_RST;
      tgt_green_r   <= COL_TGT_RST;
      tgt_blue_r    <= COL_TGT_RST;
      start_dens_r  <= '0;
      start_red_r   <= '0;
      start_green_r <= '0;
      start_blue_r  <= '0;
      fade_len_r    <= '0;
      fade_end_r    <= '0;
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) begin
        upd_r <= in_cmd && (in_fade_ticks != '0);
        // immediate change: start values stay, target shows at once
        if (in_cmd && (in_fade_ticks == '0)) begin
          tgt_dens_r  <= in_new_density;
          tgt_red_r   <= in_new_red;
          tgt_green_r <= in_new_green;
          tgt_blue_r  <= in_new_blue;
          fade_len_r  <= '0;
          fade_end_r  <= EW'(TW'(in_now));
        end
      end

      if (state_r == ST_MIX && upd_r) begin
        unique case (ch_r)
          CH_DENS:  start_dens_r  <= mix_dens;
          CH_RED:   start_red_r   <= mix_col;
          CH_GREEN: start_green_r <= mix_col;
          CH_BLUE:  start_blue_r  <= mix_col;
          default:  ;
        endcase
        if (last_ch) begin
          upd_r       <= 1'b0;
          tgt_dens_r  <= nd_r;
          tgt_red_r   <= nr_r;
          tgt_green_r <= ng_r;
          tgt_blue_r  <= nb_r;
          fade_len_r  <= ticks_r;
          fade_end_r  <= EW'(t_r) + EW'(ticks_r);
        end
      end
    end
  end

  // payload and arithmetic
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r     <= TW'(in_now);
      nd_r    <= in_new_density;
      nr_r    <= in_new_red;
      ng_r    <= in_new_green;
      nb_r    <= in_new_blue;
      ticks_r <= in_fade_ticks;
    end

    case (state_r)
      ST_SETUP: begin
        div_rem_r <= RW'(rem_clip);
        div_cnt_r <= '0;
        f_r       <= '0;
        ch_r      <= CH_DENS;
      end
      ST_DIV: begin
        div_rem_r <= div_ge ? (div_trial - RW'(fade_len_r)) : div_trial;
        div_cnt_r <= div_cnt_r + CW'(1);
        f_r       <= {f_r[QW-2:0], div_ge};
      end
      ST_MUL_S: prod_r <= mul_p;
      ST_MUL_T: begin
        acc_r  <= HALF_F + AW'(prod_r);
        prod_r <= mul_p;
      end
      ST_MIX: begin
        if (!upd_r) begin
          case (ch_r)
            CH_DENS:  res_dens_r  <= mix_dens;
            CH_RED:   res_red_r   <= to8(mix_col);
            CH_GREEN: res_green_r <= to8(mix_col);
            default:  res_blue_r  <= to8(mix_col);
          endcase
        end
        if (!last_ch) begin
          ch_r <= fpc_ch_t'(ch_r + 2'd1);
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_dens_r  <= res_dens_r;
      out_red_r   <= res_red_r;
      out_green_r <= res_green_r;
      out_blue_r  <= res_blue_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_density_out = out_dens_r;
  assign out_red_out     = out_red_r;
  assign out_green_out   = out_green_r;
  assign out_blue_out    = out_blue_r;

endmodule

### sv/fpc_checker.sv
// Port-level checker for the fog parameter crossfade unit, bound to the top level.
// Depends on fpc_pkg and fog_parameter_crossfade_unit_assert.svh.
`timescale 1ns / 1ps

`include "fog_parameter_crossfade_unit_assert.svh"

module fpc_checker
  import fpc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DENS_W-1:0] out_density_out,
  input logic [COL8_W-1:0] out_red_out,
  input logic [COL8_W-1:0] out_green_out,
  input logic [COL8_W-1:0] out_blue_out
);

  // a stalled result keeps its fields
  `FPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_density_out) && $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out))

  // one item at a time: busy right after an accept
  `FPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a new result only comes out of a busy cycle
  `FPC_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(!in_ready))

endmodule

bind fog_parameter_crossfade_unit fpc_checker u_fpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_density_out (out_density_out),
  .out_red_out     (out_red_out),
  .out_green_out   (out_green_out),
  .out_blue_out    (out_blue_out)
);
